// File: hdl/ppd_pkg.sv
// Package for the palette pixel decoder.
// Holds widths, register and format codes, and the structs shared by the decoder modules.
// No dependencies.
package ppd_pkg;

    // Frame and palette limits
    localparam int MAX_PIXELS    = 10240;
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int POS_W         = 14;
    localparam int COLOR_W       = 16;
    localparam int WORD_W        = 16;
    localparam int NIB_W         = 4;
    localparam int BYTE_W        = 8;
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam int FMT_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT  = 1'b1;

    localparam logic [FMT_W-1:0] FMT_RAW  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_NIB4 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_IDX8 = 2'd2;

    // Last pixel position of the largest frame
    localparam logic [POS_W-1:0] MAX_LAST = POS_W'(MAX_PIXELS - 1);

    localparam logic ACT_PAL_WRITE = 1'b0;
    localparam logic ACT_PIXEL     = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [PAL_AW-1:0]    palette_index;
        logic [COLOR_W-1:0]   palette_color;
        logic [WORD_W-1:0]    data_word;
    } in_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel;
        logic               frame_last;
    } pix_t;

    typedef struct packed {
        logic               we;
        logic [PAL_AW-1:0]  addr;
        logic [COLOR_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic               re;
        logic [PAL_AW-1:0]  addr;
    } ram_rd_t;

    // Pixel in flight alongside the palette read
    typedef struct packed {
        logic              valid;
        logic              use_ram;
        logic [WORD_W-1:0] raw;
        logic              last;
    } s1_t;

endpackage

// File: hdl/ppd_in_if.sv
// Input channel of the palette pixel decoder: valid/ready plus item fields.
// Depends on ppd_pkg.
interface ppd_in_if;
    import ppd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [PAL_AW-1:0]    palette_index;
    logic [COLOR_W-1:0]   palette_color;
    logic [WORD_W-1:0]    data_word;

    modport source (output valid, action, palette_index, palette_color, data_word,
                    input ready);
    modport sink   (input valid, action, palette_index, palette_color, data_word,
                    output ready);
endinterface

// File: hdl/ppd_out_if.sv
// Output channel of the palette pixel decoder: valid/ready plus pixel fields.
// Depends on ppd_pkg.
interface ppd_out_if;
    import ppd_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel;
    logic               frame_last;

    modport source (output valid, pixel, frame_last, input ready);
    modport sink   (input valid, pixel, frame_last, output ready);
endinterface

// File: hdl/palette_pixel_decoder_core.sv
// Palette pixel decoder top level. A request passes the issue stage and palette read,
// then the output queue. Throughput: one pixel per cycle while the output queue has
// room; 4-bit items give up to two pixels and hold the input while the low nibble
// waits for the one palette read port. Palette writes give no pixel. Reset clears
// position, format (raw) and frame size (10240); the colour table is not cleared.
// Depends on ppd_pkg, ppd_in_if, ppd_out_if, ppd_issue, ppd_palette_ram, ppd_out_fifo.
module palette_pixel_decoder_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ppd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppd_pkg::CFG_DATA_W-1:0] cfg_data,
    ppd_in_if.sink                         pix_in,
    ppd_out_if.source                      pix_out
);
    import ppd_pkg::*;

    in_item_t           in_item;
    ram_wr_t            ram_wr;
    ram_rd_t            ram_rd;
    s1_t                s1;
    logic [COLOR_W-1:0] ram_q;
    pix_t               push_data;
    pix_t               out_data;
    logic [FIFO_CW-1:0] fifo_cnt;
    logic [FIFO_CW-1:0] occupancy;
    logic               issue_ok;
    logic               in_ready;

    assign in_item.action        = pix_in.action;
    assign in_item.palette_index = pix_in.palette_index;
    assign in_item.palette_color = pix_in.palette_color;
    assign in_item.data_word     = pix_in.data_word;
    assign pix_in.ready          = in_ready;

    // Issue only when the queue can take the pixel plus the one in flight
    assign occupancy = fifo_cnt + FIFO_CW'(s1.valid);
    assign issue_ok  = (occupancy < FIFO_CW'(FIFO_DEPTH)) || (pix_out.valid && pix_out.ready);

    ppd_issue u_issue (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (pix_in.valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .issue_ok  (issue_ok),
        .ram_wr    (ram_wr),
        .ram_rd    (ram_rd),
        .s1        (s1)
    );

    ppd_palette_ram u_ram (
        .clk   (clk),
        .wr    (ram_wr),
        .rd    (ram_rd),
        .rdata (ram_q)
    );

    // Select palette colour or raw word
    assign push_data.pixel      = s1.use_ram ? ram_q : s1.raw;
    assign push_data.frame_last = s1.last;

    ppd_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1.valid),
        .push_data (push_data),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_data  (out_data),
        .count     (fifo_cnt)
    );

    assign pix_out.pixel      = out_data.pixel;
    assign pix_out.frame_last = out_data.frame_last;
endmodule

// File: hdl/ppd_palette_ram.sv
// Colour table: single write port, single read port, registered read data.
// Depends on ppd_pkg.
module ppd_palette_ram (
    input  logic                    clk,
    input  ppd_pkg::ram_wr_t        wr,
    input  ppd_pkg::ram_rd_t        rd,
    output logic [ppd_pkg::COLOR_W-1:0] rdata
);
    import ppd_pkg::*;

    logic [COLOR_W-1:0] mem_reg [PALETTE_DEPTH];
    logic [COLOR_W-1:0] rdata_reg;

    // Write the addressed entry
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (rd.re)
        begin
            rdata_reg <= mem_reg[rd.addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: hdl/ppd_issue.sv
// Request issue stage: configuration registers, pixel position counter,
// nibble sequencing and palette read/write issue. Depends on ppd_pkg.
module ppd_issue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ppd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ppd_pkg::in_item_t                 in_item,
    input  logic                              issue_ok,
    output ppd_pkg::ram_wr_t                  ram_wr,
    output ppd_pkg::ram_rd_t                  ram_rd,
    output ppd_pkg::s1_t                      s1
);
    import ppd_pkg::*;

    logic [FMT_W-1:0]  fmt_reg,  fmt_next;
    logic [POS_W-1:0]  last_pos_reg, last_pos_next;
    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic              second_pend_reg, second_pend_next;
    logic [NIB_W-1:0]  second_idx_reg,  second_idx_next;
    s1_t               s1_reg,   s1_next;

    logic              accept;
    logic              data_acc;
    logic              second_go;
    logic              is_last;
    logic [BYTE_W-1:0] idx_byte;

    // Hold new requests while the low nibble still waits for its read slot
    assign in_ready = !second_pend_reg && issue_ok;

    // Decode configuration writes; frame size is kept as its last position
    always_comb
    begin
        fmt_next      = fmt_reg;
        last_pos_next = last_pos_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PIXEL_FORMAT: fmt_next = cfg_data[FMT_W-1:0];
                REG_PIXEL_COUNT:
                begin
                    if (cfg_data[POS_W-1:0] > MAX_LAST)
                        last_pos_next = MAX_LAST;
                    else if (cfg_data[POS_W-1:0] == '0)
                        last_pos_next = '0;
                    else
                        last_pos_next = cfg_data[POS_W-1:0] - 1'b1;
                end
                default: ;
            endcase
        end
    end

    // One pixel per cycle if issue_ok: palette read or raw word, position advance
    always_comb
    begin
        accept    = in_valid && in_ready;
        data_acc  = accept && (in_item.action == ACT_PIXEL);
        second_go = second_pend_reg && issue_ok;
        is_last   = (pos_reg >= last_pos_reg);
        idx_byte  = in_item.data_word[BYTE_W-1:0];

        ram_wr.we   = accept && (in_item.action == ACT_PAL_WRITE);
        ram_wr.addr = in_item.palette_index;
        ram_wr.data = in_item.palette_color;

        ram_rd.re   = 1'b0;
        ram_rd.addr = '0;

        s1_next          = '0;
        s1_next.raw      = in_item.data_word;
        second_pend_next = second_pend_reg && !issue_ok;
        second_idx_next  = second_idx_reg;
        pos_next         = pos_reg;

        if (second_go)
        begin
            ram_rd.re       = 1'b1;
            ram_rd.addr     = PAL_AW'(second_idx_reg);
            s1_next.valid   = 1'b1;
            s1_next.use_ram = 1'b1;
            s1_next.last    = is_last;
        end
        else if (data_acc)
        begin
            s1_next.valid = 1'b1;
            s1_next.last  = is_last;
            case (fmt_reg)
                FMT_NIB4:
                begin
                    ram_rd.re        = 1'b1;
                    ram_rd.addr      = PAL_AW'(idx_byte[BYTE_W-1:NIB_W]);
                    s1_next.use_ram  = 1'b1;
                    // Drop the low nibble when the high one ends the frame
                    second_pend_next = !is_last;
                    second_idx_next  = idx_byte[NIB_W-1:0];
                end
                FMT_IDX8:
                begin
                    ram_rd.re       = 1'b1;
                    ram_rd.addr     = PAL_AW'(idx_byte);
                    s1_next.use_ram = 1'b1;
                end
                default: ;
            endcase
        end

        if (s1_next.valid)
        begin
            pos_next = is_last ? '0 : pos_reg + 1'b1;
        end
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg         <= FMT_RAW;
            last_pos_reg    <= MAX_LAST;
            pos_reg         <= '0;
            second_pend_reg <= 1'b0;
            second_idx_reg  <= '0;
            s1_reg          <= '0;
        end
        else
        begin
            fmt_reg         <= fmt_next;
            last_pos_reg    <= last_pos_next;
            pos_reg         <= pos_next;
            second_pend_reg <= second_pend_next;
            second_idx_reg  <= second_idx_next;
            s1_reg          <= s1_next;
        end
    end

    assign s1 = s1_reg;
endmodule

// File: hdl/ppd_out_fifo.sv
// Two-entry output queue that decouples the pixel stream from the sink.
// Depends on ppd_pkg.
module ppd_out_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  ppd_pkg::pix_t                 push_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ppd_pkg::pix_t                 out_data,
    output logic [ppd_pkg::FIFO_CW-1:0]   count
);
    import ppd_pkg::*;

    pix_t               ent_reg [FIFO_DEPTH];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] cnt_reg, cnt_next;
    logic               pop;

    // Pointer and occupancy update
    always_comb
    begin
        pop         = out_valid && out_ready;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + FIFO_CW'(push) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store pushed pixels
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign out_data  = ent_reg[rd_ptr_reg];
    assign count     = cnt_reg;
endmodule

// File: hdl/ppd_checker.sv
// Port-level checks for the palette pixel decoder, bound to the top level.
// Depends on palette_pixel_decoder_core.
module ppd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_action,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] pixel,
    input logic        frame_last
);
    logic seen_data_reg;

    // Note any accepted pixel-data request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_data_reg <= 1'b0;
        else if (in_valid && in_ready && in_action)
            seen_data_reg <= 1'b1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("pixel withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel) && $stable(frame_last))
        else $error("stalled pixel changed");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_data_reg)
        else $error("pixel produced before any data request");

    a_ready_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready && !in_ready |=> in_ready || !out_ready)
        else $error("input held off for more than one cycle with sink ready");
endmodule

bind palette_pixel_decoder_core ppd_checker u_ppd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pix_in.valid),
    .in_ready   (pix_in.ready),
    .in_action  (pix_in.action),
    .out_valid  (pix_out.valid),
    .out_ready  (pix_out.ready),
    .pixel      (pix_out.pixel),
    .frame_last (pix_out.frame_last)
);

// File: tb/sv/tb_palette_pixel_decoder_core.sv
// Testbench for palette_pixel_decoder_core: directed and random requests with a
// built-in pixel predictor and an in-order scoreboard on the pixel channel.
// Depends on ppd_pkg, ppd_in_if, ppd_out_if and the decoder RTL.
module tb_palette_pixel_decoder_core;
    import ppd_pkg::*;

    localparam logic [FMT_W-1:0] FMT_SPARE      = 2'd3;
    localparam int               SETTLE_CYCLES  = 8;
    localparam int               HOLD_CYCLES    = 80;
    localparam int               CYCLE_LIMIT    = 200000;
    localparam int               REPORT_LIMIT   = 10;
    localparam int               RANDOM_PHASES  = 10;
    localparam int               PHASE_REQUESTS = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ppd_in_if  in_ch ();
    ppd_out_if out_ch ();

    palette_pixel_decoder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (in_ch),
        .pix_out   (out_ch)
    );

    // Predictor state: colour table, written mask, registers, frame position
    logic [COLOR_W-1:0] colour_lut [PALETTE_DEPTH];
    bit                 colour_known [PALETTE_DEPTH];
    logic [FMT_W-1:0]   pred_fmt;
    logic [POS_W-1:0]   pred_count;
    logic [POS_W-1:0]   pred_pos;

    pix_t expected_pixels [$];
    int   decode_errors;
    int   cycle_count;
    bit   gaps_on;
    int   hold_requests;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Record one failure; print only the first few
    function automatic void log_error(string msg);
        decode_errors++;
        if (decode_errors <= REPORT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Push one expected pixel and advance the frame position
    function automatic bit emit_pixel(logic [COLOR_W-1:0] value);
        logic [POS_W-1:0] span;
        bit               is_last;
        pix_t             px;
        span = (pred_count > POS_W'(MAX_PIXELS)) ? POS_W'(MAX_PIXELS) : pred_count;
        if (span == '0)
            span = POS_W'(1);
        is_last = ({1'b0, pred_pos} + 15'd1 >= {1'b0, span});
        px.pixel      = value;
        px.frame_last = is_last;
        expected_pixels.push_back(px);
        pred_pos = is_last ? '0 : pred_pos + POS_W'(1);
        return is_last;
    endfunction

    // Work out the pixels that one accepted request produces
    function automatic void predict_pixels(in_item_t req);
        logic [BYTE_W-1:0] idx_byte;
        idx_byte = req.data_word[BYTE_W-1:0];
        if (req.action == ACT_PAL_WRITE)
        begin
            colour_lut[req.palette_index]   = req.palette_color;
            colour_known[req.palette_index] = 1'b1;
            return;
        end
        case (pred_fmt)
            FMT_NIB4:
            begin
                // drop the low nibble when the high one closes the frame
                if (!emit_pixel(colour_lut[idx_byte[7:4]]))
                    void'(emit_pixel(colour_lut[idx_byte[3:0]]));
            end
            FMT_IDX8: void'(emit_pixel(colour_lut[idx_byte]));
            default:  void'(emit_pixel(req.data_word));
        endcase
    endfunction

    // Build a palette write; the data word is noise
    function automatic in_item_t pal_write(logic [PAL_AW-1:0] idx, logic [COLOR_W-1:0] colour);
        in_item_t req;
        req.action        = ACT_PAL_WRITE;
        req.palette_index = idx;
        req.palette_color = colour;
        req.data_word     = WORD_W'($urandom);
        return req;
    endfunction

    // Build a pixel request; the palette fields are noise
    function automatic in_item_t pixel_word(logic [WORD_W-1:0] word);
        in_item_t req;
        req.action        = ACT_PIXEL;
        req.palette_index = PAL_AW'($urandom);
        req.palette_color = COLOR_W'($urandom);
        req.data_word     = word;
        return req;
    endfunction

    // Pick an index byte whose palette entries have all been written
    function automatic logic [BYTE_W-1:0] pick_index_byte();
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] pool [$];
        b = BYTE_W'($urandom);
        if (pred_fmt == FMT_NIB4)
        begin
            if (colour_known[b[7:4]] && colour_known[b[3:0]])
                return b;
            for (int i = 0; i < 16; i++)
                if (colour_known[i])
                    pool.push_back(BYTE_W'(i));
            b[7:4] = pool[$urandom_range(0, pool.size() - 1)][3:0];
            b[3:0] = pool[$urandom_range(0, pool.size() - 1)][3:0];
            return b;
        end
        if (colour_known[b])
            return b;
        for (int i = 0; i < PALETTE_DEPTH; i++)
            if (colour_known[i])
                pool.push_back(BYTE_W'(i));
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    // Offer one request after an optional gap and hold it until accepted
    task automatic send_request(in_item_t req);
        int gap;
        gap = 0;
        if (gaps_on)
            while ($urandom_range(0, 99) < 34)
                gap++;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= req.action;
        in_ch.palette_index <= req.palette_index;
        in_ch.palette_color <= req.palette_color;
        in_ch.data_word     <= req.data_word;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_pixels(req);
    endtask

    // Drop valid, wait for every expected pixel, then let the pipeline drain
    task automatic settle_decoder();
        in_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one configuration register while the decoder is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == REG_PIXEL_FORMAT)
            pred_fmt = data[FMT_W-1:0];
        else
            pred_count = data;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Raw words pass through at reset settings
    task automatic test_raw_passthrough();
        send_request(pixel_word(16'h0000));
        send_request(pixel_word(16'hFFFF));
        send_request(pixel_word(16'hA5A5));
        send_request(pixel_word(16'h5A5A));
        settle_decoder();
    endtask

    // Load palette entries at both ends of the table; no pixels expected
    task automatic test_palette_load();
        send_request(pal_write(8'h00, 16'hFFFF));
        send_request(pal_write(8'h0F, 16'h0000));
        send_request(pal_write(8'hF0, 16'hF800));
        send_request(pal_write(8'hFF, 16'h07E0));
        send_request(pal_write(8'h80, 16'h001F));
        send_request(pal_write(8'h5A, 16'hAAAA));
        send_request(pal_write(8'hA5, 16'h5555));
        settle_decoder();
    endtask

    // Eight-bit lookups with junk in the high byte and a short frame
    task automatic test_index8();
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_IDX8));
        write_reg(REG_PIXEL_COUNT, CFG_DATA_W'(3));
        send_request(pixel_word(16'hAB00));
        send_request(pixel_word(16'h54FF));
        send_request(pixel_word(16'hFF80));
        send_request(pixel_word(16'h005A));
        settle_decoder();
    endtask

    // Four-bit lookups with an odd frame so a low nibble gets dropped
    task automatic test_nibble();
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_NIB4));
        write_reg(REG_PIXEL_COUNT, CFG_DATA_W'(5));
        send_request(pixel_word(16'hC30F));
        send_request(pixel_word(16'h3CF0));
        send_request(pixel_word(16'hFFFF));
        send_request(pixel_word(16'h0000));
        settle_decoder();
    endtask

    // Spare format code, oversize frame, shrink below the current position, then a zero count
    task automatic test_frame_shrink();
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_SPARE));
        write_reg(REG_PIXEL_COUNT, '1);
        send_request(pixel_word(16'h1234));
        send_request(pixel_word(16'hFEDC));
        send_request(pixel_word(16'h8001));
        settle_decoder();
        write_reg(REG_PIXEL_COUNT, CFG_DATA_W'(2));
        send_request(pixel_word(16'h7FFE));
        settle_decoder();
        write_reg(REG_PIXEL_COUNT, '0);
        send_request(pixel_word(16'hCAFE));
        send_request(pixel_word(16'h0F0F));
        settle_decoder();
    endtask

    // Hold the receiver off while requests keep coming so the input stalls
    task automatic test_backpressure();
        gaps_on = 1'b1;
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_NIB4));
        write_reg(REG_PIXEL_COUNT, CFG_DATA_W'(7));
        hold_requests++;
        repeat (24)
            send_request(pixel_word({8'($urandom), pick_index_byte()}));
        settle_decoder();
    endtask

    // Random phases over formats and frame sizes, mostly small frames
    task automatic test_random_stream();
        logic [CFG_DATA_W-1:0] count;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            gaps_on = (phase != 0);
            case ($urandom_range(0, 9))
                0:       count = '0;
                1:       count = CFG_DATA_W'(1);
                2:       count = CFG_DATA_W'(2);
                3:       count = '1;
                4:       count = CFG_DATA_W'(MAX_PIXELS);
                default: count = CFG_DATA_W'($urandom_range(3, 40));
            endcase
            write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'($urandom_range(0, 3)));
            write_reg(REG_PIXEL_COUNT, count);
            if (phase == RANDOM_PHASES / 2)
                hold_requests++;
            repeat (PHASE_REQUESTS)
            begin
                if ($urandom_range(0, 99) < 25)
                    send_request(pal_write(PAL_AW'($urandom), COLOR_W'($urandom)));
                else if (pred_fmt == FMT_NIB4 || pred_fmt == FMT_IDX8)
                    send_request(pixel_word({8'($urandom), pick_index_byte()}));
                else
                    send_request(pixel_word(WORD_W'($urandom)));
            end
            settle_decoder();
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested
    initial
    begin
        int hold_left;
        int hold_seen;
        out_ch.ready = 1'b0;
        hold_left    = 0;
        hold_seen    = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (gaps_on)
                out_ch.ready <= ($urandom_range(0, 99) >= 34);
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Scoreboard: compare each accepted pixel with the oldest expectation
    initial
    begin
        pix_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                    log_error($sformatf("unexpected pixel %h last %b",
                                        out_ch.pixel, out_ch.frame_last));
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_ch.pixel !== want.pixel || out_ch.frame_last !== want.frame_last)
                        log_error($sformatf("expected pixel %h last %b, got pixel %h last %b",
                                            want.pixel, want.frame_last,
                                            out_ch.pixel, out_ch.frame_last));
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.action        = ACT_PAL_WRITE;
        in_ch.palette_index = '0;
        in_ch.palette_color = '0;
        in_ch.data_word     = '0;
        decode_errors       = 0;
        gaps_on             = 1'b1;
        hold_requests       = 0;
        pred_fmt            = FMT_RAW;
        pred_count          = POS_W'(MAX_PIXELS);
        pred_pos            = '0;
        for (int i = 0; i < PALETTE_DEPTH; i++)
        begin
            colour_lut[i]   = '0;
            colour_known[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_raw_passthrough();
        test_palette_load();
        test_index8();
        test_nibble();
        test_frame_shrink();
        test_backpressure();
        test_random_stream();

        settle_decoder();
        if (expected_pixels.size() != 0)
            log_error($sformatf("%0d pixels never arrived", expected_pixels.size()));
        if (decode_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
